// ===== rtl/core/fmm_pkg.sv =====
package fmm_pkg;

    // matrix geometry
    localparam int MaxDim = 64;
    localparam int IdxW = $clog2(MaxDim);
    localparam int AddrW = 2 * IdxW;
    localparam int DimW = 7;

    // action codes
    localparam logic [1:0] ACT_WRITE_A = 2'd0;
    localparam logic [1:0] ACT_WRITE_B = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic CFG_ORDER_N = 1'b0;
    localparam logic CFG_ROW_COUNT = 1'b1;

    localparam logic [31:0] QuietNan = 32'h7FC0_0000;

    // shared unit operation select
    localparam logic FOP_MUL = 1'b0;
    localparam logic FOP_ADD = 1'b1;

    typedef struct packed {
        logic        start;
        logic        op;
        logic [31:0] a;
        logic [31:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } fpu_rsp_t;

    // clamp a register value to 1 .. MaxDim
    function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
        logic [DimW-1:0] r;
        r = v;
        if (v == '0)
            r = DimW'(1);
        else if (32'(v) > MaxDim)
            r = DimW'(MaxDim);
        return r;
    endfunction

endpackage

// ===== rtl/core/fmm_fpu.sv =====
// shared single-precision multiply / add unit, one operation at a time
module fmm_fpu (
    input  logic              clk,
    input  logic              rst_n,
    input  fmm_pkg::fpu_req_t req,
    output fmm_pkg::fpu_rsp_t rsp
);
    import fmm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_OP   = 3'd2;
    localparam logic [2:0] S_NORM = 3'd3;
    localparam logic [2:0] S_RND  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic        op_reg;
    logic [31:0] a_reg, b_reg;
    // unpacked operands
    logic        sa_reg, sb_reg;
    logic signed [10:0] ea_reg, eb_reg;
    logic [23:0] ma_reg, mb_reg;
    logic        spec_reg;
    logic [31:0] spec_val_reg;
    // wide intermediate: value = mag * 2^(exp - 127 - 47)
    logic        rs_reg;
    logic signed [11:0] re_reg;
    logic [49:0] mag_reg;
    logic [5:0]  lz_reg;
    logic [31:0] res_reg;
    logic        done_reg;

    // operand classification
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    always_comb
    begin
        a_nan  = (a_reg[30:23] == 8'hFF) && (a_reg[22:0] != '0);
        b_nan  = (b_reg[30:23] == 8'hFF) && (b_reg[22:0] != '0);
        a_inf  = (a_reg[30:23] == 8'hFF) && (a_reg[22:0] == '0);
        b_inf  = (b_reg[30:23] == 8'hFF) && (b_reg[22:0] == '0);
        a_zero = (a_reg[30:0] == '0);
        b_zero = (b_reg[30:0] == '0);
    end

    // nan, infinity and zero operands resolved without the datapath
    logic        spec_hit;
    logic [31:0] spec_word;
    always_comb
    begin
        spec_hit  = 1'b1;
        spec_word = QuietNan;
        if (op_reg == FOP_MUL)
        begin
            if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
                spec_word = QuietNan;
            else if (a_inf || b_inf)
                spec_word = {a_reg[31] ^ b_reg[31], 8'hFF, 23'b0};
            else if (a_zero || b_zero)
                spec_word = {a_reg[31] ^ b_reg[31], 31'b0};
            else
                spec_hit = 1'b0;
        end
        else
        begin
            if (a_nan || b_nan || (a_inf && b_inf && (a_reg[31] != b_reg[31])))
                spec_word = QuietNan;
            else if (a_inf)
                spec_word = a_reg;
            else if (b_inf)
                spec_word = b_reg;
            else if (a_zero && b_zero)
                spec_word = {a_reg[31] & b_reg[31], 31'b0};
            else if (a_zero)
                spec_word = b_reg;
            else if (b_zero)
                spec_word = a_reg;
            else
                spec_hit = 1'b0;
        end
    end

    // add alignment: larger magnitude first, sticky for shifted-out bits
    logic        swap;
    logic [11:0] ediff;
    logic [49:0] big_m, sml_m, sml_sh;
    logic        sticky;
    logic [49:0] sml_full;
    always_comb
    begin
        swap = (eb_reg > ea_reg) || ((eb_reg == ea_reg) && (mb_reg > ma_reg));
        big_m = swap ? {2'b0, mb_reg, 24'b0} : {2'b0, ma_reg, 24'b0};
        sml_full = swap ? {2'b0, ma_reg, 24'b0} : {2'b0, mb_reg, 24'b0};
        ediff = swap ? 12'(eb_reg - ea_reg) : 12'(ea_reg - eb_reg);
        if (ediff > 12'd49)
        begin
            sml_sh = '0;
            sticky = (sml_full != '0);
        end
        else
        begin
            sml_sh = sml_full >> ediff[5:0];
            sticky = ((sml_full & ~({50{1'b1}} << ediff[5:0])) != '0);
        end
        sml_m = {sml_sh[49:1], sml_sh[0] | sticky};
    end

    // significand product
    logic [47:0] prod_m;
    assign prod_m = ma_reg * mb_reg;

    // leading zero count of the wide magnitude
    logic [5:0] lz;
    always_comb
    begin
        lz = 6'd50;
        for (int i = 0; i < 50; i++)
            if (mag_reg[i])
                lz = 6'(49 - i);
    end

    // normalize so the leading one sits at bit 48, handling subnormals
    logic signed [11:0] e_norm;
    logic [49:0] m_norm;
    logic [49:0] m_sh;
    logic signed [11:0] shl;
    logic        st2;
    always_comb
    begin
        // leading bit at position 49-lz; exponent of it is re_reg + (49-lz) - 47
        e_norm = re_reg + 12'sd1 - 12'(lz_reg) + 12'sd1;
        // target leading position 48
        shl = 12'(lz_reg) - 12'sd1;
        if (e_norm < 12'sd1)
            shl = shl - (12'sd1 - e_norm);
        st2 = 1'b0;
        if (shl >= 0)
            m_sh = mag_reg << shl[5:0];
        else if (-shl > 12'sd49)
        begin
            m_sh = '0;
            st2 = (mag_reg != '0);
        end
        else
        begin
            m_sh = mag_reg >> 6'(-shl);
            st2 = ((mag_reg & ~({50{1'b1}} << 6'(-shl))) != '0);
        end
        m_norm = {m_sh[49:1], m_sh[0] | st2};
        if (e_norm < 12'sd1)
            e_norm = 12'sd0;
    end

    // final rounding and packing after normalization
    logic [31:0] final_word;
    logic [23:0] fm;
    logic        fg, fs, fr;
    logic [24:0] fmr;
    logic [11:0] fe;
    always_comb
    begin
        fm = m_norm[48:25];
        fg = m_norm[24];
        fs = (m_norm[23:0] != '0);
        fr = fg && (fs || fm[0]);
        fmr = {1'b0, fm} + 25'(fr);
        fe = 12'(e_norm);
        if (fmr[24])
        begin
            fmr = fmr >> 1;
            fe = fe + 12'd1;
        end
        else if ((fe == 12'd0) && fmr[23])
            fe = 12'd1;
        if (mag_reg == '0)
            final_word = {(op_reg == FOP_MUL) ? rs_reg : 1'b0, 31'b0};
        else if ($signed(fe) >= 12'sd255)
            final_word = {rs_reg, 8'hFF, 23'b0};
        else
            final_word = {rs_reg, fe[7:0], fmr[22:0]};
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (req.start) state_next = S_PREP;
            S_PREP: state_next = S_OP;
            S_OP:   state_next = spec_reg ? S_IDLE : S_NORM;
            S_NORM: state_next = S_RND;
            S_RND:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == S_OP) && spec_reg) || (state_reg == S_RND);
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    op_reg <= req.op;
                    a_reg  <= req.a;
                    b_reg  <= req.b;
                end
            end
            S_PREP:
            begin
                sa_reg <= a_reg[31];
                sb_reg <= b_reg[31];
                ea_reg <= (a_reg[30:23] == '0) ? 11'sd1 : 11'(a_reg[30:23]);
                eb_reg <= (b_reg[30:23] == '0) ? 11'sd1 : 11'(b_reg[30:23]);
                ma_reg <= {(a_reg[30:23] != '0), a_reg[22:0]};
                mb_reg <= {(b_reg[30:23] != '0), b_reg[22:0]};
                spec_reg     <= spec_hit;
                spec_val_reg <= spec_word;
            end
            S_OP:
            begin
                if (spec_reg)
                    res_reg <= spec_val_reg;
                else if (op_reg == FOP_MUL)
                begin
                    // product 48 bits, value = mag * 2^(re-47-127)
                    rs_reg  <= sa_reg ^ sb_reg;
                    mag_reg <= {2'b0, prod_m};
                    re_reg  <= 12'(ea_reg) + 12'(eb_reg) - 12'sd126;
                end
                else
                begin
                    rs_reg <= swap ? sb_reg : sa_reg;
                    re_reg <= swap ? 12'(eb_reg) : 12'(ea_reg);
                    if (sa_reg == sb_reg)
                        mag_reg <= big_m + sml_m;
                    else
                        mag_reg <= big_m - sml_m;
                end
            end
            S_NORM:
            begin
                lz_reg <= lz;
            end
            S_RND:
            begin
                res_reg <= final_word;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.result = res_reg;

endmodule

// ===== rtl/core/float_matrix_multiply_top.sv =====
// dense single-precision matrix product, C = A x B
// input channel (in_valid / in_ready): action, row, col, value
//   action write A / write B stores value at (row, col), no result
//   action compute returns C[row][col] on the output channel
// output channel (out_valid / out_ready): product_value, product_row, product_col
// config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): order_n, row_count
// a load is written to its store on acceptance; a compute runs from
//   acceptance to result on one shared float unit doing each multiply
//   and then each add in turn, with a store read for each term
// the block takes one item at a time and is not ready while it works
// out-of-range computes and action 3 give no result
// the result waits in an output register while the receiver stalls;
//   the next item is taken meanwhile and held until that register frees
// reset sets order_n and row_count to 64; stores are undefined until written
module float_matrix_multiply_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [5:0]  row,
    input  logic [5:0]  col,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] product_value,
    output logic [5:0]  product_row,
    output logic [5:0]  product_col,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    import fmm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [DimW-1:0] order_reg, rows_reg;
    logic [IdxW-1:0] row_reg, col_reg;
    logic [DimW-1:0] k_reg;
    logic [31:0] acc_reg, prod_reg;
    logic [31:0] a_rd_reg, b_rd_reg;
    logic        waiting_add_reg;
    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    logic [IdxW-1:0] out_row_reg, out_col_reg;

    logic [31:0] a_mem [MaxDim*MaxDim];
    logic [31:0] b_mem [MaxDim*MaxDim];

    fpu_req_t fpu_req;
    fpu_rsp_t fpu_rsp;

    fmm_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .rsp   (fpu_rsp)
    );

    logic in_fire;
    logic [DimW-1:0] n_eff, rows_eff;
    logic in_range;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign n_eff     = clamp_dim(order_reg);
    assign rows_eff  = clamp_dim(rows_reg);
    assign in_range  = (DimW'(row) < rows_eff) && (DimW'(col) < n_eff);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= DimW'(MaxDim);
            rows_reg  <= DimW'(MaxDim);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_ORDER_N)
                order_reg <= cfg_data;
            else
                rows_reg <= cfg_data;
        end
    end

    // store writes and reads
    logic [AddrW-1:0] a_addr, b_addr;
    assign a_addr = {row_reg, k_reg[IdxW-1:0]};
    assign b_addr = {k_reg[IdxW-1:0], col_reg};
    always_ff @(posedge clk)
    begin
        if (in_fire && (action == ACT_WRITE_A))
            a_mem[{row, col}] <= value;
        if (in_fire && (action == ACT_WRITE_B))
            b_mem[{row, col}] <= value;
        a_rd_reg <= a_mem[a_addr];
        b_rd_reg <= b_mem[b_addr];
    end

    // sequencer
    logic last_k;
    assign last_k = (k_reg + DimW'(1) == n_eff);
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_fire && (action == ACT_COMPUTE) && in_range)
                    state_next = S_RD;
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_WAIT;
            S_WAIT:
                if (fpu_rsp.done)
                    state_next = waiting_add_reg ? (last_k ? S_OUT : S_RD) : S_ADD;
            S_ADD:  state_next = S_WAIT;
            S_OUT:  if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        fpu_req.start = (state_reg == S_MUL) || (state_reg == S_ADD);
        fpu_req.op    = (state_reg == S_ADD) ? FOP_ADD : FOP_MUL;
        fpu_req.a     = (state_reg == S_ADD) ? acc_reg : a_rd_reg;
        fpu_req.b     = (state_reg == S_ADD) ? prod_reg : b_rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            waiting_add_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_MUL)
                waiting_add_reg <= 1'b0;
            else if (state_reg == S_ADD)
                waiting_add_reg <= 1'b1;
            if ((state_reg == S_OUT) && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            row_reg <= row;
            col_reg <= col;
            k_reg   <= '0;
            acc_reg <= '0;
        end
        if ((state_reg == S_WAIT) && fpu_rsp.done)
        begin
            if (waiting_add_reg)
            begin
                acc_reg <= fpu_rsp.result;
                k_reg   <= k_reg + DimW'(1);
            end
            else
                prod_reg <= fpu_rsp.result;
        end
        if ((state_reg == S_OUT) && (!out_valid_reg || out_ready))
        begin
            out_value_reg <= acc_reg;
            out_row_reg   <= row_reg;
            out_col_reg   <= col_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign product_value = out_value_reg;
    assign product_row   = out_row_reg;
    assign product_col   = out_col_reg;

    // checks
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (k_reg < n_eff))
        else $error("k index beyond order");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> !in_ready)
        else $error("ready while computing");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(out_value_reg))
        else $error("result changed while stalled");

endmodule

// ===== tb/fmm_checker.sv =====
`timescale 1ns / 1ps

module fmm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [5:0]  row,
    input  logic [5:0]  col,
    input  logic [31:0] value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] product_value,
    input  logic [5:0]  product_row,
    input  logic [5:0]  product_col,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    output int          fail_count,
    output int          pending
);
    import fmm_pkg::*;

    typedef struct packed {
        logic [31:0] entry;
        logic [5:0]  r;
        logic [5:0]  c;
    } entry_word_t;

    logic [31:0] a_mem [MaxDim*MaxDim];
    logic [31:0] b_mem [MaxDim*MaxDim];
    logic [6:0]  order_reg;
    logic [6:0]  rows_reg;
    entry_word_t entry_q [$];

    // round a magnitude m * 2^(e-150) to single precision, nearest even
    function automatic logic [31:0] round_single(input bit s, input int e, input logic [63:0] m);
        int p;
        int sh;
        int e2;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        p = 63;
        while (!m[p]) p--;
        sh = p - 23;
        e2 = e + sh;
        if (e2 < 1)
        begin
            sh = sh + (1 - e2);
            e2 = 1;
        end
        if (sh <= 0)
            kept = m << (-sh);
        else if (sh > 62)
            kept = '0;
        else
        begin
            kept = m >> sh;
            rem  = m & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && kept[0]))
                kept = kept + 64'd1;
        end
        if (kept[24])
        begin
            kept = kept >> 1;
            e2++;
        end
        if (e2 >= 255)
            return {s, 8'hFF, 23'd0};
        return {s, kept[23] ? 8'(e2) : 8'd0, kept[22:0]};
    endfunction

    function automatic bit is_nan(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != '0;
    endfunction

    function automatic bit is_inf(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] == '0;
    endfunction

    function automatic logic [31:0] single_mul(input logic [31:0] x, input logic [31:0] y);
        bit s;
        int ex;
        int ey;
        logic [63:0] mx;
        logic [63:0] my;
        s = x[31] ^ y[31];
        if (is_nan(x) || is_nan(y))
            return QuietNan;
        if (is_inf(x) || is_inf(y))
        begin
            if (x[30:0] == '0 || y[30:0] == '0)
                return QuietNan;
            return {s, 8'hFF, 23'd0};
        end
        if (x[30:0] == '0 || y[30:0] == '0)
            return {s, 31'd0};
        ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
        ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
        mx = {40'd0, x[30:23] != 0, x[22:0]};
        my = {40'd0, y[30:23] != 0, y[22:0]};
        return round_single(s, ex + ey - 150, mx * my);
    endfunction

    function automatic logic [31:0] single_add(input logic [31:0] x, input logic [31:0] y);
        bit sx;
        bit sy;
        bit s;
        int ex;
        int ey;
        int d;
        logic [63:0] mx;
        logic [63:0] my;
        logic [63:0] t;
        logic [63:0] m;
        if (is_nan(x) || is_nan(y))
            return QuietNan;
        if (is_inf(x) && is_inf(y) && x[31] != y[31])
            return QuietNan;
        if (is_inf(x))
            return x;
        if (is_inf(y))
            return y;
        if (x[30:0] == '0 && y[30:0] == '0)
            return {x[31] & y[31], 31'd0};
        if (x[30:0] == '0)
            return y;
        if (y[30:0] == '0)
            return x;
        sx = x[31];
        sy = y[31];
        ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
        ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
        mx = {40'd0, x[30:23] != 0, x[22:0]} << 32;
        my = {40'd0, y[30:23] != 0, y[22:0]} << 32;
        // larger exponent first
        if (ex < ey)
        begin
            t = mx; mx = my; my = t;
            d = ex; ex = ey; ey = d;
            s = sx; sx = sy; sy = s;
        end
        d = ex - ey;
        if (d > 60)
            my = 64'd1;
        else if (d > 0)
            my = (my >> d) | 64'((my & ((64'd1 << d) - 64'd1)) != 0);
        if (sx == sy)
        begin
            m = mx + my;
            s = sx;
        end
        else if (mx >= my)
        begin
            m = mx - my;
            s = sx;
        end
        else
        begin
            m = my - mx;
            s = sy;
        end
        if (m == 0)
            return 32'd0;
        return round_single(s, ex - 32, m);
    endfunction

    // dot product of A row r and B column c over n terms
    function automatic logic [31:0] dot_entry(input int r, input int c, input int n);
        logic [31:0] acc;
        acc = 32'd0;
        for (int k = 0; k < n; k++)
            acc = single_add(acc, single_mul(a_mem[r*MaxDim + k], b_mem[k*MaxDim + c]));
        if (is_nan(acc))
            acc = QuietNan;
        return acc;
    endfunction

    function automatic int clamp_reg(input logic [6:0] v);
        if (v == 0)
            return 1;
        if (int'(v) > MaxDim)
            return MaxDim;
        return int'(v);
    endfunction

    initial
    begin
        for (int i = 0; i < MaxDim*MaxDim; i++)
        begin
            a_mem[i] = '0;
            b_mem[i] = '0;
        end
    end

    // watch the channels, predict and compare
    always @(posedge clk or negedge rst_n)
    begin
        entry_word_t got;
        entry_word_t want;
        if (!rst_n)
        begin
            order_reg  = 7'd64;
            rows_reg   = 7'd64;
            fail_count = 0;
            pending    = 0;
            entry_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ORDER_N)
                    order_reg = cfg_data;
                else
                    rows_reg = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                if (action == ACT_WRITE_A)
                    a_mem[{row, col}] = value;
                else if (action == ACT_WRITE_B)
                    b_mem[{row, col}] = value;
                else if (action == ACT_COMPUTE && int'(row) < clamp_reg(rows_reg)
                         && int'(col) < clamp_reg(order_reg))
                    entry_q.push_back({dot_entry(row, col, clamp_reg(order_reg)), row, col});
            end
            if (out_valid && out_ready)
            begin
                got = {product_value, product_row, product_col};
                if (entry_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word: value %h row %0d col %0d",
                                 product_value, product_row, product_col);
                end
                else
                begin
                    want = entry_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result word differs: exp %h (%0d,%0d) got %h (%0d,%0d)",
                                     want.entry, want.r, want.c,
                                     product_value, product_row, product_col);
                    end
                end
            end
            pending = entry_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import fmm_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int QuietLimit = 20000;
    localparam int SettleCycles = 2 + 13 * MaxDim + 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = '0;
    logic [5:0]  row = '0;
    logic [5:0]  col = '0;
    logic [31:0] value = '0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [31:0] product_value;
    logic [5:0]  product_row;
    logic [5:0]  product_col;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [6:0]  cfg_data = '0;
    int          fail_count;
    int          pending;

    int  send_idle = 8;
    int  recv_idle = 66;
    bit  stall_req = 1'b0;
    bit  stall_done = 1'b0;
    int  quiet = 0;
    int  sent = 0;
    int  n_eff = MaxDim;
    int  rows_eff = MaxDim;
    bit  a_ok [MaxDim*MaxDim];
    bit  b_ok [MaxDim*MaxDim];

    float_matrix_multiply_top DUT (.*);

    fmm_checker u_checker (.*);

    always #6 clk = ~clk;

    // abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QuietLimit)
        begin
            $display("float_matrix_multiply_top: mismatch");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_req && !stall_done)
            begin
                out_ready = 1'b0;
                repeat (1500) @(negedge clk);
                stall_done = 1'b1;
            end
            out_ready = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    function automatic logic [31:0] rand_float();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return {$urandom_range(0, 1) == 1, 31'd0};
            2: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
            3: return {$urandom_range(0, 1) == 1, 8'hFF, ($urandom_range(0, 1) == 1) ? 23'd0 : 23'($urandom)};
            default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(118, 136)), 23'($urandom)};
        endcase
    endfunction

    // one input word, entered and left at a falling edge
    task automatic send_word(input logic [1:0] act, input logic [5:0] r, input logic [5:0] c,
                             input logic [31:0] v);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        action = act;
        row = r;
        col = c;
        value = v;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (act == ACT_WRITE_A)
            a_ok[{r, c}] = 1'b1;
        else if (act == ACT_WRITE_B)
            b_ok[{r, c}] = 1'b1;
        sent++;
        if (sent == 650)
        begin
            send_idle = 66;
            recv_idle = 8;
        end
        else if (sent == 1300)
        begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    // load whatever the entry still lacks, then request it
    task automatic request_entry(input int r, input int c);
        for (int k = 0; k < n_eff; k++)
        begin
            if (!a_ok[r*MaxDim + k])
                send_word(ACT_WRITE_A, 6'(r), 6'(k), rand_float());
            if (!b_ok[k*MaxDim + c])
                send_word(ACT_WRITE_B, 6'(k), 6'(c), rand_float());
        end
        send_word(ACT_COMPUTE, 6'(r), 6'(c), $urandom);
    endtask

    // wait for all results, let the block drain, then write both registers
    task automatic set_dims(input logic [6:0] n, input logic [6:0] rows);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
        for (int i = 0; i < 2; i++)
        begin
            cfg_valid = 1'b1;
            cfg_index = (i == 0) ? CFG_ORDER_N : CFG_ROW_COUNT;
            cfg_data = (i == 0) ? n : rows;
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
            cfg_valid = 1'b0;
        end
        n_eff = (n == 0) ? 1 : (int'(n) > MaxDim) ? MaxDim : int'(n);
        rows_eff = (rows == 0) ? 1 : (int'(rows) > MaxDim) ? MaxDim : int'(rows);
    endtask

    task automatic random_phase(input int count, input bit hold_off);
        int stop;
        int pick;
        int r;
        int c;
        stop = sent + count;
        while (sent < stop)
        begin
            if (hold_off && sent > stop - count / 2)
                stall_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // few distinct entries at large sizes to keep loads short
                if (n_eff > 16)
                begin
                    r = ($urandom_range(0, 1) == 1) ? rows_eff - 1 : 0;
                    c = ($urandom_range(0, 1) == 1) ? n_eff - 1 : 0;
                end
                else
                begin
                    r = $urandom_range(0, rows_eff - 1);
                    c = $urandom_range(0, n_eff - 1);
                end
                request_entry(r, c);
            end
            else if (pick < 65 && rows_eff < MaxDim)
                send_word(ACT_COMPUTE, 6'($urandom_range(rows_eff, MaxDim - 1)), 6'($urandom), $urandom);
            else if (pick < 65 && n_eff < MaxDim)
                send_word(ACT_COMPUTE, 6'($urandom), 6'($urandom_range(n_eff, MaxDim - 1)), $urandom);
            else if (pick < 72)
                send_word(ACT_UNUSED, 6'($urandom), 6'($urandom), $urandom);
            else
                send_word(($urandom_range(0, 1) == 1) ? ACT_WRITE_B : ACT_WRITE_A,
                          6'($urandom), 6'($urandom), rand_float());
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, overflow, subnormals, nan, ignored items
        set_dims(7'd4, 7'd3);
        send_word(ACT_WRITE_A, 6'd0, 6'd0, 32'h3F80_0000);
        send_word(ACT_WRITE_A, 6'd0, 6'd1, 32'h7F7F_FFFF);
        send_word(ACT_WRITE_A, 6'd0, 6'd2, 32'h0000_0001);
        send_word(ACT_WRITE_A, 6'd0, 6'd3, 32'h8000_0000);
        send_word(ACT_WRITE_B, 6'd0, 6'd0, 32'h3F80_0000);
        send_word(ACT_WRITE_B, 6'd1, 6'd0, 32'h7F7F_FFFF);
        send_word(ACT_WRITE_B, 6'd2, 6'd0, 32'h8000_0001);
        send_word(ACT_WRITE_B, 6'd3, 6'd0, 32'h0000_0000);
        request_entry(0, 0);
        send_word(ACT_WRITE_A, 6'd1, 6'd0, 32'h7F80_0000);
        send_word(ACT_WRITE_A, 6'd1, 6'd1, 32'hFFFF_FFFF);
        send_word(ACT_WRITE_B, 6'd0, 6'd1, 32'h0000_0000);
        request_entry(1, 1);
        request_entry(1, 0);
        send_word(ACT_COMPUTE, 6'd3, 6'd0, 32'h0);
        send_word(ACT_COMPUTE, 6'd0, 6'd63, 32'h0);
        send_word(ACT_UNUSED, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_word(ACT_WRITE_A, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_word(ACT_WRITE_B, 6'd63, 6'd63, 32'h0000_0000);
        request_entry(2, 3);

        // random phases over several sizes, out-of-range register values too
        set_dims(7'd1, 7'd1);
        random_phase(150, 1'b0);
        set_dims(7'd0, 7'd0);
        random_phase(100, 1'b0);
        set_dims(7'd2, 7'd64);
        random_phase(250, 1'b0);
        set_dims(7'd8, 7'd5);
        random_phase(300, 1'b1);
        set_dims(7'd5, 7'd8);
        random_phase(250, 1'b0);
        set_dims(7'd16, 7'd16);
        random_phase(300, 1'b0);
        set_dims(7'd127, 7'd2);
        random_phase(200, 1'b0);
        set_dims(7'd64, 7'd127);
        random_phase(200, 1'b0);
        set_dims(7'd3, 7'd4);
        random_phase(200, 1'b0);

        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
        if (fail_count == 0)
            $display("float_matrix_multiply_top: match");
        else
            $display("float_matrix_multiply_top: mismatch");
        $finish;
    end

endmodule
